/* rtl/psm_pkg.sv */
// Package for the packed slot map: sizes, command/status codes, controller types.
// Used by every module of the block except psm_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package psm_pkg;

    localparam int CAPACITY  = 1024;
    localparam int ID_W      = $clog2(CAPACITY);
    localparam int SLOT_W    = $clog2(CAPACITY + 1);
    localparam int HANDLE_W  = 10;
    localparam int FIELD_W   = 11;

    localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(CAPACITY);

    localparam int S_FIELDS_W = HANDLE_W + 1;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 * FIELD_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_SET     = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic rd1;
        logic rd2;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic two_step;
        logic out_free;
    } ctrl_stat_t;

endpackage
`default_nettype wire

/* rtl/packed_slot_map_with_free_ids_top.sv */
// Top level of the packed slot map with free-id list: controller plus datapath.
// Depends on psm_pkg, psm_ctrl, psm_datapath (and psm_ram below it).
//
//  port group | dir | tdata (lsb up)                                  | tuser
//  s_*        | in  | handle_id[9:0], flag_value[10], zero pad        | command[1:0]
//  m_*        | out | result_id[10:0], packed_index[21:11],           | status[1:0]
//             |     | flag_out[22], live_count[33:23], zero pad       |
//
// Each word steps through load, a registered id-table read, then a second table
// step (swap move or flag read) for destroy and query only, then commit.
// The output register lets the next word be taken while a result waits.
// Reset clears counters, free-list head, output valid and controller state only; tables are written before use.
// A stalled output holds the block in its commit step; no table write is lost.
`timescale 1ns / 1ps
`default_nettype none
module packed_slot_map_with_free_ids_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [psm_pkg::S_DATA_W-1:0]  s_tdata,  // handle_id, flag_value
    input  wire logic [1:0]                    s_tuser,  // command
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [psm_pkg::M_DATA_W-1:0]  m_tdata,  // result_id, packed_index,
                                                         // flag_out, live_count
    output logic      [1:0]                    m_tuser   // status
);

    psm_pkg::ctrl_cmd_t  cmd;
    psm_pkg::ctrl_stat_t stat;

    psm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    psm_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> cmd.rd1)
        else $error("accepted word not followed by table read");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("commit while output register blocked");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.rd1, cmd.rd2, cmd.commit}))
        else $error("more than one controller step active");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

endmodule
`default_nettype wire

/* rtl/psm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/psm_ctrl.sv */
// Controller FSM: sequences load, table reads and commit for one word at a time.
// Depends on psm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire psm_pkg::ctrl_stat_t stat,
    output psm_pkg::ctrl_cmd_t       cmd
);

    psm_pkg::state_t state_reg;
    psm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            psm_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = psm_pkg::S_RD1;
                end
            end
            psm_pkg::S_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = stat.two_step ? psm_pkg::S_RD2 : psm_pkg::S_FIN;
            end
            psm_pkg::S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = psm_pkg::S_FIN;
            end
            psm_pkg::S_FIN:
            begin
                cmd.commit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = psm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = psm_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/psm_datapath.sv */
// Datapath: command registers, id/slot/flag tables, free list, counters, output register.
// Depends on psm_pkg and psm_ram.
`timescale 1ns / 1ps
`default_nettype none
module psm_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire psm_pkg::ctrl_cmd_t               cmd,
    output psm_pkg::ctrl_stat_t                   stat,
    input  wire logic [psm_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [psm_pkg::M_DATA_W-1:0]     m_tdata,
    output logic      [1:0]                       m_tuser
);

    localparam int ID_W   = psm_pkg::ID_W;
    localparam int SLOT_W = psm_pkg::SLOT_W;
    localparam int FW     = psm_pkg::FIELD_W;
    localparam int PAD_W  = psm_pkg::M_DATA_W - psm_pkg::M_FIELDS_W;

    psm_pkg::cmd_t                   op_reg;
    logic [psm_pkg::HANDLE_W-1:0]    id_reg;
    logic                            fv_reg;

    logic [SLOT_W-1:0] fresh_reg;
    logic [SLOT_W-1:0] fresh_next;
    logic [SLOT_W-1:0] free_head_reg;
    logic [SLOT_W-1:0] free_head_next;
    logic [SLOT_W-1:0] count_reg;
    logic [SLOT_W-1:0] count_next;

    logic                          out_valid_reg;
    logic [psm_pkg::M_DATA_W-1:0]  out_data_reg;
    logic [1:0]                    out_user_reg;

    logic [SLOT_W-1:0] i2s_q;
    logic [SLOT_W-1:0] s2i_q;
    logic              sel_q;

    logic              i2s_we;
    logic [ID_W-1:0]   i2s_waddr;
    logic [SLOT_W-1:0] i2s_wdata;
    logic [ID_W-1:0]   i2s_raddr;
    logic              s2i_we;
    logic [ID_W-1:0]   s2i_waddr;
    logic [SLOT_W-1:0] s2i_wdata;
    logic              sel_we;
    logic [ID_W-1:0]   sel_waddr;
    logic              sel_wdata;
    logic              sel_re;
    logic [ID_W-1:0]   sel_raddr;

    logic              fh_valid;
    logic              is_full;
    logic              is_empty;
    logic              id_oor;
    logic [SLOT_W-1:0] last_slot;
    logic [SLOT_W-1:0] new_id;
    logic [SLOT_W-1:0] id_ext;
    logic              lk_valid;
    logic [SLOT_W-1:0] d_slot;
    logic              lid_valid;
    logic              crt_ok;
    logic              dst_ok;
    logic              set_ok;

    logic [SLOT_W-1:0] res_id;
    logic [SLOT_W-1:0] res_slot;
    logic              res_flag;
    logic [SLOT_W-1:0] res_count;
    psm_pkg::status_t  res_status;

    // command word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= psm_pkg::cmd_t'(s_tuser);
            id_reg <= s_tdata[psm_pkg::HANDLE_W-1:0];
            fv_reg <= s_tdata[psm_pkg::HANDLE_W];
        end
    end

    assign fh_valid  = free_head_reg < psm_pkg::NONE_SLOT;
    assign is_full   = (count_reg >= psm_pkg::NONE_SLOT)
                       || (!fh_valid && (fresh_reg >= psm_pkg::NONE_SLOT));
    assign is_empty  = count_reg == '0;
    assign id_oor    = 32'(id_reg) >= 32'(psm_pkg::CAPACITY);
    assign last_slot = count_reg - SLOT_W'(1);
    assign new_id    = fh_valid ? free_head_reg : fresh_reg;
    assign id_ext    = SLOT_W'(id_reg);
    assign lk_valid  = i2s_q < psm_pkg::NONE_SLOT;
    assign d_slot    = lk_valid ? i2s_q : last_slot;
    assign lid_valid = s2i_q < psm_pkg::NONE_SLOT;
    assign crt_ok    = (op_reg == psm_pkg::CMD_CREATE) && !is_full;
    assign dst_ok    = (op_reg == psm_pkg::CMD_DESTROY) && !id_oor && !is_empty;
    assign set_ok    = (op_reg == psm_pkg::CMD_SET) && !id_oor && lk_valid;

    assign stat.two_step = op_reg inside {psm_pkg::CMD_DESTROY, psm_pkg::CMD_QUERY};
    assign stat.out_free = !out_valid_reg || m_tready;

    // read ports
    assign i2s_raddr = (op_reg == psm_pkg::CMD_CREATE) ? free_head_reg[ID_W-1:0]
                                                      : ID_W'(id_reg);
    assign sel_re    = cmd.rd1 || cmd.rd2;
    assign sel_raddr = cmd.rd2 ? i2s_q[ID_W-1:0] : last_slot[ID_W-1:0];

    // writes: rd2 swap-moves last entry; commit creates, links destroyed id, sets flag
    always_comb
    begin
        i2s_we    = 1'b0;
        i2s_waddr = '0;
        i2s_wdata = '0;
        s2i_we    = 1'b0;
        s2i_waddr = '0;
        s2i_wdata = '0;
        sel_we    = 1'b0;
        sel_waddr = '0;
        sel_wdata = 1'b0;
        if (cmd.rd2 && dst_ok)
        begin
            i2s_we    = lid_valid;
            i2s_waddr = s2i_q[ID_W-1:0];
            i2s_wdata = d_slot;
            s2i_we    = 1'b1;
            s2i_waddr = d_slot[ID_W-1:0];
            s2i_wdata = s2i_q;
            sel_we    = 1'b1;
            sel_waddr = d_slot[ID_W-1:0];
            sel_wdata = sel_q;
        end
        else if (cmd.commit && crt_ok)
        begin
            i2s_we    = 1'b1;
            i2s_waddr = new_id[ID_W-1:0];
            i2s_wdata = count_reg;
            s2i_we    = 1'b1;
            s2i_waddr = count_reg[ID_W-1:0];
            s2i_wdata = new_id;
            sel_we    = 1'b1;
            sel_waddr = count_reg[ID_W-1:0];
            sel_wdata = 1'b0;
        end
        else if (cmd.commit && dst_ok)
        begin
            i2s_we    = 1'b1;
            i2s_waddr = ID_W'(id_reg);
            i2s_wdata = free_head_reg;
            s2i_we    = 1'b1;
            s2i_waddr = last_slot[ID_W-1:0];
            s2i_wdata = psm_pkg::NONE_SLOT;
        end
        else if (cmd.commit && set_ok)
        begin
            sel_we    = 1'b1;
            sel_waddr = i2s_q[ID_W-1:0];
            sel_wdata = fv_reg;
        end
    end

    psm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (psm_pkg::CAPACITY)
    ) u_id_to_slot (
        .clk   (clk),
        .we    (i2s_we),
        .waddr (i2s_waddr),
        .wdata (i2s_wdata),
        .re    (cmd.rd1),
        .raddr (i2s_raddr),
        .rdata (i2s_q)
    );

    psm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (psm_pkg::CAPACITY)
    ) u_slot_to_id (
        .clk   (clk),
        .we    (s2i_we),
        .waddr (s2i_waddr),
        .wdata (s2i_wdata),
        .re    (cmd.rd1),
        .raddr (last_slot[ID_W-1:0]),
        .rdata (s2i_q)
    );

    psm_ram #(
        .WIDTH (1),
        .DEPTH (psm_pkg::CAPACITY)
    ) u_selected (
        .clk   (clk),
        .we    (sel_we),
        .waddr (sel_waddr),
        .wdata (sel_wdata),
        .re    (sel_re),
        .raddr (sel_raddr),
        .rdata (sel_q)
    );

    // result word
    always_comb
    begin
        res_id     = id_ext;
        res_slot   = psm_pkg::NONE_SLOT;
        res_flag   = 1'b0;
        res_count  = count_reg;
        res_status = psm_pkg::ST_OK;
        case (op_reg)
            psm_pkg::CMD_CREATE:
            begin
                if (is_full)
                begin
                    res_id     = psm_pkg::NONE_SLOT;
                    res_status = psm_pkg::ST_FULL;
                end
                else
                begin
                    res_id    = new_id;
                    res_slot  = count_reg;
                    res_count = count_reg + SLOT_W'(1);
                end
            end
            psm_pkg::CMD_DESTROY:
            begin
                if (id_oor)
                begin
                    res_status = psm_pkg::ST_RANGE;
                end
                else if (is_empty)
                begin
                    res_status = psm_pkg::ST_EMPTY;
                end
                else
                begin
                    res_count = last_slot;
                end
            end
            default:
            begin
                if (id_oor)
                begin
                    res_status = psm_pkg::ST_RANGE;
                end
                else if (lk_valid)
                begin
                    res_slot = i2s_q;
                    res_flag = (op_reg == psm_pkg::CMD_SET) ? fv_reg : sel_q;
                end
            end
        endcase
    end

    // free list and counters
    always_comb
    begin
        fresh_next     = fresh_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        if (cmd.commit && crt_ok)
        begin
            count_next = count_reg + SLOT_W'(1);
            if (fh_valid)
            begin
                free_head_next = lk_valid ? i2s_q : psm_pkg::NONE_SLOT;
            end
            else
            begin
                fresh_next = fresh_reg + SLOT_W'(1);
            end
        end
        else if (cmd.commit && dst_ok)
        begin
            count_next     = last_slot;
            free_head_next = id_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= '0;
            free_head_reg <= psm_pkg::NONE_SLOT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg     <= fresh_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, FW'(res_count), res_flag,
                             FW'(res_slot), FW'(res_id)};
            out_user_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire
